// File: src/tcs_pkg.sv
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared constants, opcodes and types of the text console cursor/scroll core.
// ----------------------------------------------------------------------------
`default_nettype none

package tcs_pkg;

    // Screen geometry
    localparam int COLS = 80;
    localparam int ROWS = 25;

    localparam int CELLS  = COLS * ROWS;
    localparam int COPY_N = (ROWS - 1) * COLS;
    localparam int ADDR_W = $clog2(CELLS);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(COPY_N - 1);
    localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(COPY_N);
    localparam logic [ADDR_W-1:0] ROW_OFS   = ADDR_W'(COLS);

    localparam logic [6:0] COL_LAST = 7'(COLS - 1);
    localparam logic [4:0] ROW_LAST = 5'(ROWS - 1);

    // Character codes
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_RETURN  = 8'd13;
    localparam logic [7:0] CH_SPACE   = 8'd32;

    // Input action codes
    localparam logic [2:0] ACT_PUT   = 3'd0;
    localparam logic [2:0] ACT_SET   = 3'd1;
    localparam logic [2:0] ACT_BACK  = 3'd2;
    localparam logic [2:0] ACT_CLEAR = 3'd3;
    localparam logic [2:0] ACT_READ  = 3'd4;

    // Decoded operations carried to the back end
    typedef logic [2:0] op_t;
    localparam op_t OP_NOP     = 3'd0;
    localparam op_t OP_PUT     = 3'd1;
    localparam op_t OP_NEWLINE = 3'd2;
    localparam op_t OP_RETURN  = 3'd3;
    localparam op_t OP_SET     = 3'd4;
    localparam op_t OP_BACK    = 3'd5;
    localparam op_t OP_CLEAR   = 3'd6;
    localparam op_t OP_READ    = 3'd7;

    // Command queue depth (power of two)
    localparam int CQ_DEPTH = 4;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);

    typedef struct packed {
        op_t               op;
        logic [7:0]        ch;
        logic [7:0]        attr;
        logic [6:0]        col;
        logic [4:0]        row;
        logic              rd_ok;
        logic [ADDR_W-1:0] rd_addr;
    } cmd_t;

    typedef struct packed {
        logic [6:0] col;
        logic [4:0] row;
        logic [7:0] ch;
        logic [7:0] attr;
        logic       scroll;
    } res_t;

    typedef struct packed {
        logic init_busy;
        logic res_valid;
    } back_stat_t;

endpackage

`default_nettype wire

// File: src/tcs_ram.sv
// ----------------------------------------------------------------------------
// tcs_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: src/tcs_front.sv
// ----------------------------------------------------------------------------
// tcs_front
// Request decoder: classifies the action, clamps the cursor target and
// forms the read address with its range check.
// ----------------------------------------------------------------------------
`default_nettype none

module tcs_front (
    input  wire logic [2:0]   action,
    input  wire logic [7:0]   char_code,
    input  wire logic [7:0]   color,
    input  wire logic [9:0]   col,
    input  wire logic [9:0]   row,
    output tcs_pkg::cmd_t     cmd
);
    import tcs_pkg::*;

    logic       col_in;
    logic       row_in;
    logic [6:0] col_cl;
    logic [4:0] row_cl;

    // Range checks on the signed coordinates
    assign col_in = !col[9] && (col < 10'(COLS));
    assign row_in = !row[9] && (row < 10'(ROWS));

    // Clamp to the screen
    assign col_cl = col[9] ? 7'd0 : (col_in ? col[6:0] : COL_LAST);
    assign row_cl = row[9] ? 5'd0 : (row_in ? row[4:0] : ROW_LAST);

    // Classify the request
    always_comb
    begin
        cmd.ch      = char_code;
        cmd.attr    = color;
        cmd.col     = col_cl;
        cmd.row     = row_cl;
        cmd.rd_ok   = col_in && row_in;
        cmd.rd_addr = ADDR_W'(row[4:0]) * ROW_OFS + ADDR_W'(col[6:0]);
        case (action)
            ACT_PUT:
            begin
                if (char_code == CH_NEWLINE)
                begin
                    cmd.op = OP_NEWLINE;
                end
                else if (char_code == CH_RETURN)
                begin
                    cmd.op = OP_RETURN;
                end
                else
                begin
                    cmd.op = OP_PUT;
                end
            end
            ACT_SET:   cmd.op = OP_SET;
            ACT_BACK:  cmd.op = OP_BACK;
            ACT_CLEAR: cmd.op = OP_CLEAR;
            ACT_READ:  cmd.op = OP_READ;
            default:   cmd.op = OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

// File: src/tcs_cmd_queue.sv
// ----------------------------------------------------------------------------
// tcs_cmd_queue
// Short FIFO of decoded requests between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module tcs_cmd_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  tcs_pkg::cmd_t       wr_cmd,
    output logic                q_full,
    input  wire logic           rd_en,
    output logic                q_valid,
    output tcs_pkg::cmd_t       rd_cmd
);
    import tcs_pkg::*;

    cmd_t                entry_reg [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] wr_ptr_reg;
    logic [CQ_PTR_W-1:0] wr_ptr_next;
    logic [CQ_PTR_W-1:0] rd_ptr_reg;
    logic [CQ_PTR_W-1:0] rd_ptr_next;
    logic [CQ_PTR_W:0]   count_reg;
    logic [CQ_PTR_W:0]   count_next;
    logic                do_wr;
    logic                do_rd;

    assign q_full  = (count_reg == (CQ_PTR_W+1)'(CQ_DEPTH));
    assign q_valid = (count_reg != '0);
    assign rd_cmd  = entry_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && q_valid;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + (do_wr ? CQ_PTR_W'(1) : CQ_PTR_W'(0));
        rd_ptr_next = rd_ptr_reg + (do_rd ? CQ_PTR_W'(1) : CQ_PTR_W'(0));
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + (CQ_PTR_W+1)'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - (CQ_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the request
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

`default_nettype wire

// File: src/tcs_back.sv
// ----------------------------------------------------------------------------
// tcs_back
// Execution engine: owns the cursor, the screen RAM and the fill color,
// runs the clear, scroll and reset-clear sweeps and holds one result.
// ----------------------------------------------------------------------------
`default_nettype none

module tcs_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_we,
    input  wire logic [7:0]     cfg_data,
    input  wire logic           q_valid,
    input  tcs_pkg::cmd_t       q_cmd,
    output logic                q_pop,
    input  wire logic           res_pop,
    output tcs_pkg::res_t       res,
    output tcs_pkg::back_stat_t stat
);
    import tcs_pkg::*;

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_COPY  = 3'd3;
    localparam logic [2:0] S_FILL  = 3'd4;
    localparam logic [2:0] S_CLEAR = 3'd5;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [ADDR_W-1:0] k_reg;
    logic [ADDR_W-1:0] k_next;
    logic              pend_valid_reg;
    logic              pend_valid_next;
    logic [ADDR_W-1:0] pend_addr_reg;
    logic [ADDR_W-1:0] pend_addr_next;
    logic [6:0]        cur_col_reg;
    logic [6:0]        cur_col_next;
    logic [4:0]        cur_row_reg;
    logic [4:0]        cur_row_next;
    logic [7:0]        fill_color_reg;
    logic [7:0]        clear_attr_reg;
    logic [7:0]        clear_attr_next;
    logic              res_valid_reg;
    logic              res_valid_next;
    res_t              res_reg;
    res_t              res_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [15:0]       ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [15:0]       ram_rdata;

    logic              finish;
    logic [7:0]        fin_char;
    logic [7:0]        fin_color;
    logic              fin_scroll;
    logic [6:0]        bs_col;
    logic [ADDR_W-1:0] row_base;

    assign row_base = ADDR_W'(cur_row_reg) * ROW_OFS;
    assign bs_col   = (cur_col_reg != 7'd0) ? (cur_col_reg - 7'd1) : cur_col_reg;

    assign res            = res_reg;
    assign stat.init_busy = (state_reg == S_INIT);
    assign stat.res_valid = res_valid_reg;

    tcs_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;
        clear_attr_next = clear_attr_reg;
        res_valid_next  = res_valid_reg;
        res_next        = res_reg;
        ram_we          = 1'b0;
        ram_waddr       = k_reg;
        ram_wdata       = 16'd0;
        ram_raddr       = k_reg + ROW_OFS;
        q_pop           = 1'b0;
        finish          = 1'b0;
        fin_char        = 8'd0;
        fin_color       = 8'd0;
        fin_scroll      = 1'b0;

        // Drop the result once taken
        if (res_pop && res_valid_reg)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                ram_we = 1'b1;
                k_next = k_reg + ADDR_W'(1);
                if (k_reg == LAST_ADDR)
                begin
                    k_next     = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid && !res_valid_reg)
                begin
                    q_pop = 1'b1;
                    case (q_cmd.op)
                        OP_PUT:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = row_base + ADDR_W'(cur_col_reg);
                            ram_wdata = {q_cmd.attr, q_cmd.ch};
                            if (cur_col_reg == COL_LAST)
                            begin
                                cur_col_next = 7'd0;
                                if (cur_row_reg == ROW_LAST)
                                begin
                                    k_next     = '0;
                                    state_next = S_COPY;
                                end
                                else
                                begin
                                    cur_row_next = cur_row_reg + 5'd1;
                                    finish       = 1'b1;
                                end
                            end
                            else
                            begin
                                cur_col_next = cur_col_reg + 7'd1;
                                finish       = 1'b1;
                            end
                        end
                        OP_NEWLINE:
                        begin
                            cur_col_next = 7'd0;
                            if (cur_row_reg == ROW_LAST)
                            begin
                                k_next     = '0;
                                state_next = S_COPY;
                            end
                            else
                            begin
                                cur_row_next = cur_row_reg + 5'd1;
                                finish       = 1'b1;
                            end
                        end
                        OP_RETURN:
                        begin
                            cur_col_next = 7'd0;
                            finish       = 1'b1;
                        end
                        OP_SET:
                        begin
                            cur_col_next = q_cmd.col;
                            cur_row_next = q_cmd.row;
                            finish       = 1'b1;
                        end
                        OP_BACK:
                        begin
                            cur_col_next = bs_col;
                            ram_we       = 1'b1;
                            ram_waddr    = row_base + ADDR_W'(bs_col);
                            ram_wdata    = {q_cmd.attr, CH_SPACE};
                            finish       = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            clear_attr_next = q_cmd.attr;
                            k_next          = '0;
                            state_next      = S_CLEAR;
                        end
                        OP_READ:
                        begin
                            if (q_cmd.rd_ok)
                            begin
                                ram_raddr  = q_cmd.rd_addr;
                                state_next = S_READ;
                            end
                            else
                            begin
                                finish = 1'b1;
                            end
                        end
                        default:
                        begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                fin_char   = ram_rdata[7:0];
                fin_color  = ram_rdata[15:8];
                finish     = 1'b1;
                state_next = S_IDLE;
            end
            S_COPY:
            begin
                // Read one row below, write it back on the next cycle
                ram_raddr       = k_reg + ROW_OFS;
                pend_valid_next = 1'b1;
                pend_addr_next  = k_reg;
                k_next          = k_reg + ADDR_W'(1);
                if (k_reg == COPY_LAST)
                begin
                    k_next     = COPY_END;
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                if (!pend_valid_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = k_reg;
                    ram_wdata = {fill_color_reg, CH_SPACE};
                    k_next    = k_reg + ADDR_W'(1);
                    if (k_reg == LAST_ADDR)
                    begin
                        k_next     = '0;
                        fin_scroll = 1'b1;
                        finish     = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = {clear_attr_reg, CH_SPACE};
                k_next    = k_reg + ADDR_W'(1);
                if (k_reg == LAST_ADDR)
                begin
                    k_next       = '0;
                    cur_col_next = 7'd0;
                    cur_row_next = 5'd0;
                    finish       = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Pending copy write takes the write port
        if (pend_valid_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = pend_addr_reg;
            ram_wdata = ram_rdata;
        end

        // Capture the result
        if (finish)
        begin
            res_valid_next  = 1'b1;
            res_next.col    = cur_col_next;
            res_next.row    = cur_row_next;
            res_next.ch     = fin_char;
            res_next.attr   = fin_color;
            res_next.scroll = fin_scroll;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            k_reg          <= '0;
            pend_valid_reg <= 1'b0;
            cur_col_reg    <= 7'd0;
            cur_row_reg    <= 5'd0;
            res_valid_reg  <= 1'b0;
            fill_color_reg <= 8'd15;
        end
        else
        begin
            state_reg      <= state_next;
            k_reg          <= k_next;
            pend_valid_reg <= pend_valid_next;
            cur_col_reg    <= cur_col_next;
            cur_row_reg    <= cur_row_next;
            res_valid_reg  <= res_valid_next;
            if (cfg_we)
            begin
                fill_color_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_addr_reg  <= pend_addr_next;
        clear_attr_reg <= clear_attr_next;
        res_reg        <= res_next;
    end

endmodule

`default_nettype wire

// File: src/text_console_cursor_scroll_core.sv
// Put, return, newline, set cursor and backspace finish in the execution engine's
// idle state unless they scroll; a cell read goes through a read state for the
// registered screen RAM read. Clear sweeps every cell; a scroll copies each row up
// and then fills the last row, the copy and fill sharing the one RAM write port.
// The engine starts no new request while a result waits to be popped. After reset
// the screen RAM is zeroed in one pass over all cells during which full stays high.
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_core
// Text console top level: request decoder, command queue and execution engine.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_scroll_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_data,
    input  wire logic       push,
    output logic            full,
    input  wire logic [2:0] action,
    input  wire logic [7:0] char_code,
    input  wire logic [7:0] color,
    input  wire logic [9:0] col,
    input  wire logic [9:0] row,
    output logic            empty,
    input  wire logic       pop,
    output logic [6:0]      cursor_col,
    output logic [4:0]      cursor_row,
    output logic [7:0]      cell_char,
    output logic [7:0]      cell_color,
    output logic            did_scroll
);
    import tcs_pkg::*;

    cmd_t       front_cmd;
    cmd_t       q_cmd;
    logic       q_full;
    logic       q_valid;
    logic       q_pop;
    res_t       res;
    back_stat_t stat;

    assign full  = q_full || stat.init_busy;
    assign empty = !stat.res_valid;

    assign cursor_col = res.col;
    assign cursor_row = res.row;
    assign cell_char  = res.ch;
    assign cell_color = res.attr;
    assign did_scroll = res.scroll;

    tcs_front u_front (
        .action    (action),
        .char_code (char_code),
        .color     (color),
        .col       (col),
        .row       (row),
        .cmd       (front_cmd)
    );

    tcs_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && !full),
        .wr_cmd  (front_cmd),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .q_valid (q_valid),
        .rd_cmd  (q_cmd)
    );

    tcs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .res_pop  (pop),
        .res      (res),
        .stat     (stat)
    );

    // Hold off requests during the reset clear
    a_init_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        stat.init_busy |-> full)
        else $error("request path open during screen clear");

    // Start a request only with the result slot free
    a_pop_slot: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> empty)
        else $error("request started while a result waits");

    // Keep the reported cursor on the screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (cursor_col <= COL_LAST) && (cursor_row <= ROW_LAST))
        else $error("cursor off screen");

    // Leave the cursor on the last row after a scroll
    a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && did_scroll) |-> (cursor_row == ROW_LAST) && (cursor_col == 7'd0))
        else $error("scroll left cursor off the last row");

endmodule

`default_nettype wire

// File: verif/text_console_cursor_scroll_core_tb.sv
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_core_tb
// Self-checking bench for the text console core. A queue-fed driver offers
// console requests while a shadow screen, cursor and fill color predict
// every response; a monitor pops responses and compares them field by field.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcs_pkg::*;

    localparam int          TIMEOUT_NS     = 120_000_000;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          HOLD_CYCLES    = 150;
    localparam int          PHASE_REQS     = 250;
    localparam logic [7:0]  FILL_AT_RESET  = 8'd15;
    localparam logic [2:0]  ACT_SPARE_FIRST = 3'd5;
    localparam logic [2:0]  ACT_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] ch;
        logic [7:0] attr;
        logic [9:0] col;
        logic [9:0] row;
    } console_req_t;

    typedef struct packed {
        logic [6:0] cur_col;
        logic [4:0] cur_row;
        logic [7:0] ch;
        logic [7:0] attr;
        logic       scrolled;
    } console_view_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [7:0] cfg_data = 8'h00;
    logic       push = 1'b0;
    logic       full;
    logic [2:0] action = 3'd0;
    logic [7:0] char_code = 8'h00;
    logic [7:0] color = 8'h00;
    logic [9:0] col = 10'd0;
    logic [9:0] row = 10'd0;
    logic       empty;
    logic       pop = 1'b0;
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic [7:0] cell_char;
    logic [7:0] cell_color;
    logic       did_scroll;

    // Shadow console state
    logic [15:0]   screen [CELLS] = '{default: 16'h0000};
    int            cur_x = 0;
    int            cur_y = 0;
    logic [7:0]    fill_attr = FILL_AT_RESET;

    console_req_t  req_backlog [$];
    console_view_t outcome_q [$];
    console_req_t  cur_req;
    int            errors = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            hold_ask = 0;
    int            hold_seen = 0;
    int            hold_left = 0;

    text_console_cursor_scroll_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .action     (action),
        .char_code  (char_code),
        .color      (color),
        .col        (col),
        .row        (row),
        .empty      (empty),
        .pop        (pop),
        .cursor_col (cursor_col),
        .cursor_row (cursor_row),
        .cell_char  (cell_char),
        .cell_color (cell_color),
        .did_scroll (did_scroll)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

    // Apply one request to the shadow console and return its response
    task automatic apply_request(input console_req_t rq, output console_view_t rs);
        int          c;
        int          r;
        int          i;
        logic [15:0] cell_word;
        rs = '0;
        c = int'($signed(rq.col));
        r = int'($signed(rq.row));
        case (rq.action)
            ACT_PUT:
            begin
                if (rq.ch == CH_NEWLINE)
                begin
                    cur_x = 0;
                    cur_y++;
                end
                else if (rq.ch == CH_RETURN)
                begin
                    cur_x = 0;
                end
                else
                begin
                    screen[cur_y * COLS + cur_x] = {rq.attr, rq.ch};
                    cur_x++;
                    if (cur_x >= COLS)
                    begin
                        cur_x = 0;
                        cur_y++;
                    end
                end
                // Scroll up one row when the cursor leaves the bottom
                if (cur_y >= ROWS)
                begin
                    for (i = 0; i < (ROWS - 1) * COLS; i++)
                        screen[i] = screen[i + COLS];
                    for (i = (ROWS - 1) * COLS; i < CELLS; i++)
                        screen[i] = {fill_attr, CH_SPACE};
                    cur_y = ROWS - 1;
                    rs.scrolled = 1'b1;
                end
            end
            ACT_SET:
            begin
                if (c < 0) c = 0;
                if (r < 0) r = 0;
                if (c >= COLS) c = COLS - 1;
                if (r >= ROWS) r = ROWS - 1;
                cur_x = c;
                cur_y = r;
            end
            ACT_BACK:
            begin
                if (cur_x > 0)
                    cur_x--;
                screen[cur_y * COLS + cur_x] = {rq.attr, CH_SPACE};
            end
            ACT_CLEAR:
            begin
                for (i = 0; i < CELLS; i++)
                    screen[i] = {rq.attr, CH_SPACE};
                cur_x = 0;
                cur_y = 0;
            end
            ACT_READ:
            begin
                if (c >= 0 && c < COLS && r >= 0 && r < ROWS)
                begin
                    cell_word = screen[r * COLS + c];
                    rs.ch = cell_word[7:0];
                    rs.attr = cell_word[15:8];
                end
            end
            default:
            begin
            end
        endcase
        rs.cur_col = 7'(cur_x);
        rs.cur_row = 5'(cur_y);
    endtask

    function automatic console_req_t mk_req(logic [2:0] a, logic [7:0] ch, logic [7:0] attr,
                                            int c, int r);
        console_req_t rq;
        rq.action = a;
        rq.ch = ch;
        rq.attr = attr;
        rq.col = 10'(c);
        rq.row = 10'(r);
        return rq;
    endfunction

    // Build a random request, weighted toward puts and near-bottom cursor moves
    function automatic console_req_t random_req();
        console_req_t rq;
        int           pick;
        int           sub;
        pick = $urandom_range(0, 99);
        sub = $urandom_range(0, 19);
        rq.ch = 8'($urandom);
        rq.attr = 8'($urandom);
        rq.col = 10'($urandom);
        rq.row = 10'($urandom);
        if (pick < 50)
        begin
            rq.action = ACT_PUT;
            if (sub < 3)
                rq.ch = CH_NEWLINE;
            else if (sub == 3)
                rq.ch = CH_RETURN;
        end
        else if (pick < 64)
        begin
            rq.action = ACT_SET;
            if (sub < 5)
                rq.row = 10'($urandom_range(ROWS - 2, ROWS - 1));
            if (sub >= 5 && sub < 15)
            begin
                rq.col = 10'($urandom_range(0, COLS - 1));
                rq.row = 10'($urandom_range(0, ROWS - 1));
            end
        end
        else if (pick < 72)
        begin
            rq.action = ACT_BACK;
        end
        else if (pick < 73)
        begin
            rq.action = ACT_CLEAR;
        end
        else if (pick < 95)
        begin
            rq.action = ACT_READ;
            if (sub >= 5)
            begin
                rq.col = 10'($urandom_range(0, COLS - 1));
                rq.row = (sub < 10) ? 10'(ROWS - 1) : 10'($urandom_range(0, ROWS - 1));
            end
        end
        else
        begin
            rq.action = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
        end
        return rq;
    endfunction

    function automatic void check_field(string what, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
            errors++;
        end
    endfunction

    // Driver: offer backlog requests, hold while full, predict on accept
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        console_view_t view;
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                apply_request(cur_req, view);
                outcome_q.push_back(view);
            end
            if (!push || !full)
            begin
                if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    cur_req = req_backlog.pop_front();
                    push <= 1'b1;
                    action <= cur_req.action;
                    char_code <= cur_req.ch;
                    color <= cur_req.attr;
                    col <= cur_req.col;
                    row <= cur_req.row;
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor: pop responses, compare against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : watch_proc
        console_view_t want;
        if (!rst_n)
        begin
            pop <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (outcome_q.size() == 0)
                begin
                    $display("%0t: response with no request outstanding, expected none, got col %0d row %0d",
                             $time, cursor_col, cursor_row);
                    errors++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    check_field("cursor_col", want.cur_col, cursor_col);
                    check_field("cursor_row", want.cur_row, cursor_row);
                    check_field("cell_char", want.ch, cell_char);
                    check_field("cell_color", want.attr, cell_color);
                    check_field("did_scroll", want.scrolled, did_scroll);
                end
            end
            // Hold off popping for a long stretch when asked
            if (hold_ask != hold_seen)
            begin
                hold_seen <= hold_ask;
                hold_left <= HOLD_CYCLES;
                pop <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                pop <= 1'b0;
            end
            else
            begin
                pop <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Wait until every request is issued and answered, then let the block settle
    task automatic wait_quiet();
        while (req_backlog.size() != 0 || push || outcome_q.size() != 0)
        begin
            @(posedge clk);
            #1;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_fill_color(input logic [7:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        fill_attr = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_random(input int n);
        int k;
        for (k = 0; k < n; k++)
            req_backlog.push_back(random_req());
    endtask

    initial
    begin : stimulus
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct <= 26;
        recv_idle_pct <= 83;

        // Directed corners with the fill color at its reset value
        req_backlog.push_back(mk_req(ACT_READ, 8'h00, 8'h00, 0, 0));
        req_backlog.push_back(mk_req(ACT_PUT, 8'h41, 8'h1E, 0, 0));
        req_backlog.push_back(mk_req(ACT_PUT, 8'hFF, 8'h00, 0, 0));
        req_backlog.push_back(mk_req(ACT_PUT, CH_RETURN, 8'h00, 0, 0));
        req_backlog.push_back(mk_req(ACT_READ, 8'h00, 8'h00, 1, 0));
        req_backlog.push_back(mk_req(ACT_BACK, 8'h00, 8'hAA, 0, 0));
        req_backlog.push_back(mk_req(ACT_SET, 8'h00, 8'h00, -512, -512));
        req_backlog.push_back(mk_req(ACT_SET, 8'hFF, 8'hFF, 511, 511));
        req_backlog.push_back(mk_req(ACT_PUT, 8'h80, 8'hFF, 0, 0));
        req_backlog.push_back(mk_req(ACT_READ, 8'h00, 8'h00, COLS - 1, ROWS - 2));
        req_backlog.push_back(mk_req(ACT_READ, 8'h00, 8'h00, 0, ROWS - 1));
        req_backlog.push_back(mk_req(ACT_PUT, CH_NEWLINE, 8'h00, 0, 0));
        req_backlog.push_back(mk_req(ACT_PUT, 8'h7E, 8'h33, 0, 0));
        req_backlog.push_back(mk_req(ACT_PUT, CH_RETURN, 8'h00, 0, 0));
        req_backlog.push_back(mk_req(ACT_READ, 8'h00, 8'h00, -1, 0));
        req_backlog.push_back(mk_req(ACT_READ, 8'h00, 8'h00, COLS, 0));
        req_backlog.push_back(mk_req(ACT_READ, 8'h00, 8'h00, 0, ROWS));
        req_backlog.push_back(mk_req(ACT_READ, 8'h00, 8'h00, COLS - 1, ROWS - 1));
        req_backlog.push_back(mk_req(ACT_SPARE_FIRST, 8'h41, 8'h12, 3, 3));
        req_backlog.push_back(mk_req(ACT_SPARE_FIRST + 3'd1, 8'h00, 8'h00, 0, 0));
        req_backlog.push_back(mk_req(ACT_SPARE_LAST, 8'hFF, 8'hFF, -1, -1));
        req_backlog.push_back(mk_req(ACT_SET, 8'h00, 8'h00, 5, 3));
        req_backlog.push_back(mk_req(ACT_BACK, 8'h00, 8'h55, 0, 0));
        req_backlog.push_back(mk_req(ACT_CLEAR, 8'h00, 8'h00, 0, 0));
        req_backlog.push_back(mk_req(ACT_READ, 8'h00, 8'h00, COLS - 1, ROWS - 1));
        wait_quiet();

        // Sender lightly idle, receiver mostly idle, with one long pop hold-off
        write_fill_color(8'h00);
        queue_random(PHASE_REQS);
        @(posedge clk);
        hold_ask <= hold_ask + 1;
        wait_quiet();

        // Swap the idle ratios
        write_fill_color(8'hFF);
        send_idle_pct <= 83;
        recv_idle_pct <= 26;
        queue_random(PHASE_REQS);
        wait_quiet();

        // Run back to back
        write_fill_color(8'($urandom));
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        queue_random(PHASE_REQS);
        wait_quiet();

        if (errors == 0 && outcome_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: filelist.f
src/tcs_pkg.sv
src/tcs_ram.sv
src/tcs_front.sv
src/tcs_cmd_queue.sv
src/tcs_back.sv
src/text_console_cursor_scroll_core.sv
verif/text_console_cursor_scroll_core_tb.sv
